// ===== src/assert_macros.svh =====
// Assertion macros shared by the priority queue RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define SMPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define SMPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/smpq_pkg.sv =====
// Package for the sorted minimum priority queue: sizes, opcodes and cell control.
// Used by smpq_cell and sorted_min_priority_queue; depends on nothing else.
package smpq_pkg;

  localparam int CAPACITY  = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 5;

  // Request opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  del;
    data_t key;
  } ctrl_t;

endpackage

// ===== src/smpq_cell.sv =====
// One storage cell of the sorted chain: holds a key and exchanges data with neighbors.
// Depends on smpq_pkg.
module smpq_cell import smpq_pkg::*; (
  input  logic  clk_i,
  input  ctrl_t ctrl_i,
  input  logic  valid_i,
  input  logic  prev_keep_i,
  input  data_t left_data_i,
  input  data_t right_data_i,
  output logic  keep_o,
  output data_t data_o,
  output data_t data_d_o
);

  data_t data_q, data_d;
  logic  keep;

  // A valid cell keeps its entry on insert when it is not above the new key.
  assign keep = valid_i && (data_q <= ctrl_i.key);

  // Next value: hold, take the new key, shift back on insert, or shift forward on delete.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (keep) begin
        data_d = data_q;
      end else if (prev_keep_i) begin
        data_d = ctrl_i.key;
      end else begin
        data_d = left_data_i;
      end
    end else if (ctrl_i.del) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign keep_o   = keep;
  assign data_o   = data_q;
  assign data_d_o = data_d;

endmodule

// ===== src/sorted_min_priority_queue.sv =====
// Top level of the sorted minimum priority queue: cell chain, count and result register.
// Depends on smpq_pkg, smpq_cell and assert_macros.svh.
//
// Usage: a request enters on the s_axis channel. s_axis_tuser selects the operation
// (0 inserts the signed key in s_axis_tdata, 1 removes the smallest entry). Each
// request gives exactly one result on the m_axis channel: removed key, new smallest
// key, entry count and, in m_axis_tuser, an error flag for an insert into a full
// queue or a delete from an empty one; a failed request leaves the store unchanged.
// Equal keys leave in the order they arrived.
// m_axis_tvalid rises in the cycle after acceptance. The whole chain of 16 cells
// compares and shifts in parallel for each request, so one request per cycle is
// accepted as long as the result register is empty or is being drained in the same
// cycle.
// When the receiver stalls, the result is held in the output register and
// s_axis_tready drops until it is taken.
// Reset empties the queue (count zero) and clears the output valid; the stored keys
// are not cleared and no request is blocked after reset.
`include "assert_macros.svh"

module sorted_min_priority_queue import smpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [DATA_W-1:0]        s_axis_tdata,  // [31:0] value
  input  logic [0:0]               s_axis_tuser,  // [0] opcode
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [2*DATA_W+7:0]      m_axis_tdata,  // [31:0] removed_value,
                                                  // [63:32] front_value,
                                                  // [68:64] entry_count, rest zero
  output logic [0:0]               m_axis_tuser   // [0] error_flag
);

  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  data_t                removed_q, front_q;
  logic [OUT_CNT_W-1:0] out_count_q;
  logic                 err_q;

  logic  in_acc, is_del, full, empty, ins_ok, del_ok, req_err;
  ctrl_t ctrl;
  logic  keep   [CAPACITY];
  data_t cell_q [CAPACITY];
  data_t cell_d [CAPACITY];

  // Request decode.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign is_del  = (s_axis_tuser[0] == OP_DELETE);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign ins_ok  = in_acc && !is_del && !full;
  assign del_ok  = in_acc && is_del && !empty;
  assign req_err = (!is_del && full) || (is_del && empty);

  assign ctrl.ins = ins_ok;
  assign ctrl.del = del_ok;
  assign ctrl.key = data_t'(s_axis_tdata);

  // Chain of cells; each looks at its neighbors only.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  prev_keep;
    data_t left_data, right_data;
    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
      assign left_data = ctrl.key;
    end else begin : g_mid
      assign prev_keep = keep[i-1];
      assign left_data = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_q[i];
    end else begin : g_inner
      assign right_data = cell_q[i+1];
    end
    smpq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .valid_i      (count_q > CNT_W'(i)),
      .prev_keep_i  (prev_keep),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .keep_o       (keep[i]),
      .data_o       (cell_q[i]),
      .data_d_o     (cell_d[i])
    );
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, loaded when a request is accepted.
  assign out_valid_d = in_acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      removed_q   <= del_ok ? cell_q[0] : '0;
      front_q     <= (count_d != '0) ? cell_d[0] : '0;
      out_count_q <= OUT_CNT_W'(count_d);
      err_q       <= req_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_count_q, front_q, removed_q};
  assign m_axis_tuser  = err_q;

  // Checks on the count, the order of the two front cells and the empty-delete error flag.
  `SMPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `SMPQ_ASSERT(a_front_order, clk_i, rst_ni, (count_q < CNT_W'(2)) || (cell_q[0] <= cell_q[1]), "front cells out of order")
  `SMPQ_ASSERT_NEXT(a_insert_count, clk_i, rst_ni, ins_ok, count_q == $past(count_q) + CNT_W'(1), "insert did not raise count")
  `SMPQ_ASSERT_NEXT(a_empty_delete, clk_i, rst_ni, in_acc && is_del && empty, m_axis_tvalid && err_q && (count_q == '0), "empty delete not flagged")

endmodule
